// File: design/utf8_permissive_decoder_macros.svh
// Assertion macros used by the permissive UTF-8 decoder RTL.
`ifndef UTF8_PERMISSIVE_DECODER_MACROS_SVH
`define UTF8_PERMISSIVE_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define U8PD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("utf8 decoder assertion failed");
// Condition that must never be true outside reset.
`define U8PD_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("utf8 decoder forbidden condition seen");
`else
`define U8PD_ASSERT(label, prop)
`define U8PD_NEVER(label, cond)
`endif

`endif

// File: design/utf8pd_pkg.sv
// Package: types, constants and helper functions of the permissive UTF-8 decoder.
`timescale 1ns / 1ps
package utf8pd_pkg;

	localparam logic [20:0] QMARK = 21'h00003F;

	// Sequence length codes given by a lead byte.
	localparam logic [2:0] LEN_BAD   = 3'd0;
	localparam logic [2:0] LEN_ASCII = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	typedef struct packed {
		logic [1:0] held_cnt;
		logic [2:0] seq_len;
	} seq_state_t;

	typedef struct packed {
		logic       we;
		logic [1:0] idx;
		logic [7:0] data;
	} hold_wr_t;

	typedef struct packed {
		logic [1:0]       cnt;
		logic             last;
		logic [2:0][20:0] cp;
	} res_grp_t;

	function automatic logic [2:0] lead_len(input logic [7:0] c);
		logic [2:0] len;
		if (c[7] == 1'b0) begin
			len = LEN_ASCII;
		end else if (c[7:5] == 3'b110) begin
			len = LEN_TWO;
		end else if (c[7:4] == 4'b1110) begin
			len = LEN_THREE;
		end else if (c[7:3] == 5'b11110) begin
			len = LEN_FOUR;
		end else begin
			len = LEN_BAD;
		end
		return len;
	endfunction

	function automatic logic [20:0] assemble(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] len);
		logic [20:0] v;
		case (len)
			LEN_TWO:   v = {10'd0, b0[4:0], b1[5:0]};
			LEN_THREE: v = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			LEN_FOUR:  v = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			default:   v = QMARK;
		endcase
		return v;
	endfunction

endpackage

// File: design/utf8pd_in_if.sv
// Interface of the byte input channel.
`timescale 1ns / 1ps
interface utf8pd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_string;

	modport source (output valid, output byte_in, output end_of_string, input ready);
	modport sink (input valid, input byte_in, input end_of_string, output ready);
endinterface

// File: design/utf8pd_out_if.sv
// Interface of the code point output channel.
`timescale 1ns / 1ps
interface utf8pd_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        last_of_string;

	modport source (output valid, output code_point, output last_of_string, input ready);
	modport sink (input valid, input code_point, input last_of_string, output ready);
endinterface

// File: design/utf8pd_decode.sv
// Combinational decode of one byte against the open sequence into a group of results.
`timescale 1ns / 1ps
module utf8pd_decode (
	input  logic [7:0]              byte_in,
	input  logic                    end_of_string,
	input  utf8pd_pkg::seq_state_t  st,
	input  logic [2:0][7:0]         held,
	output utf8pd_pkg::seq_state_t  st_nxt,
	output utf8pd_pkg::hold_wr_t    hold_wr,
	output utf8pd_pkg::res_grp_t    grp
);
	import utf8pd_pkg::*;

	logic [2:0] len;
	logic [2:0] len_b1;
	logic [2:0] len_b2;
	logic [7:0] buf0, buf1, buf2, buf3;
	logic [2:0] n;

	always_comb begin
		len    = lead_len(byte_in);
		buf0   = held[0];
		buf1   = (st.held_cnt >= 2'd2) ? held[1] : byte_in;
		buf2   = (st.held_cnt == 2'd3) ? held[2] : byte_in;
		buf3   = byte_in;
		len_b1 = lead_len(buf1);
		len_b2 = lead_len(buf2);
		n      = {1'b0, st.held_cnt} + 3'd1;

		st_nxt       = st;
		hold_wr.we   = 1'b0;
		hold_wr.idx  = st.held_cnt;
		hold_wr.data = byte_in;
		grp.cnt      = 2'd0;
		grp.last     = end_of_string;
		grp.cp       = '0;

		if (st.seq_len == 3'd0 || st.held_cnt == 2'd0) begin
			st_nxt = '0;
			if (len == LEN_ASCII) begin
				grp.cnt   = 2'd1;
				grp.cp[0] = {13'd0, byte_in};
			end else if (len == LEN_BAD || end_of_string) begin
				grp.cnt   = 2'd1;
				grp.cp[0] = QMARK;
			end else begin
				hold_wr.we     = 1'b1;
				hold_wr.idx    = 2'd0;
				st_nxt.held_cnt = 2'd1;
				st_nxt.seq_len  = len;
			end
		end else if (n >= st.seq_len) begin
			grp.cnt   = 2'd1;
			grp.cp[0] = assemble(buf0, buf1, buf2, buf3, st.seq_len);
			st_nxt    = '0;
		end else if (end_of_string) begin
			// The truncated lead gives '?' and the bytes after it start afresh.
			st_nxt    = '0;
			grp.cp[0] = QMARK;
			if (len_b1 == LEN_TWO && n == 3'd3) begin
				grp.cnt   = 2'd2;
				grp.cp[1] = assemble(buf1, buf2, 8'd0, 8'd0, LEN_TWO);
			end else begin
				grp.cp[1] = (len_b1 == LEN_ASCII) ? {13'd0, buf1} : QMARK;
				grp.cp[2] = (len_b2 == LEN_ASCII) ? {13'd0, buf2} : QMARK;
				grp.cnt   = (n == 3'd3) ? 2'd3 : 2'd2;
			end
		end else begin
			hold_wr.we      = 1'b1;
			st_nxt.held_cnt = n[1:0];
		end
	end

endmodule

// File: design/utf8_permissive_decoder.sv
// A code point is registered, valid in the cycle after its byte is accepted. Throughput
// while the output is ready: one byte per cycle; a string end inside an open sequence
// yields up to three code points, and the input then waits while that group drains,
// one per cycle. Reset (arst_n low, asynchronous) closes any open sequence and empties
// the output register; the held bytes are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`include "utf8_permissive_decoder_macros.svh"
module utf8_permissive_decoder (
	input logic         clk,
	input logic         arst_n,
	utf8pd_in_if.sink   byte_ch,
	utf8pd_out_if.source cp_ch
);
	import utf8pd_pkg::*;

	seq_state_t       st_q;
	seq_state_t       st_nxt;
	logic [2:0][7:0]  held_q;
	hold_wr_t         hold_wr;
	res_grp_t         grp;
	logic [1:0]       cnt_q;
	logic             last_q;
	logic [2:0][20:0] cp_q;
	logic             in_acc;
	logic             out_acc;

	utf8pd_decode u_decode (
		.byte_in       (byte_ch.byte_in),
		.end_of_string (byte_ch.end_of_string),
		.st            (st_q),
		.held          (held_q),
		.st_nxt        (st_nxt),
		.hold_wr       (hold_wr),
		.grp           (grp)
	);

	// A new transaction is taken when the result register is empty or frees this cycle.
	assign byte_ch.ready     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && cp_ch.ready);
	assign in_acc            = byte_ch.valid && byte_ch.ready;
	assign out_acc           = cp_ch.valid && cp_ch.ready;
	assign cp_ch.valid       = (cnt_q != 2'd0);
	assign cp_ch.code_point  = cp_q[0];
	assign cp_ch.last_of_string = last_q && (cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			cnt_q <= 2'd0;
		end else if (in_acc) begin
			st_q  <= st_nxt;
			cnt_q <= grp.cnt;
		end else if (out_acc) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cp_q   <= grp.cp;
			last_q <= grp.last;
		end else if (out_acc) begin
			cp_q[0] <= cp_q[1];
			cp_q[1] <= cp_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && hold_wr.we) begin
			held_q[hold_wr.idx] <= hold_wr.data;
		end
	end

	`U8PD_ASSERT(a_open_seq_consistent, st_q.seq_len != 3'd0 |-> st_q.held_cnt != 2'd0)
	`U8PD_ASSERT(a_held_below_len, st_q.seq_len == 3'd0 || 3'(st_q.held_cnt) < st_q.seq_len)
	`U8PD_ASSERT(a_closed_seq_empty, st_q.seq_len == 3'd0 |-> st_q.held_cnt == 2'd0)
	`U8PD_ASSERT(a_end_closes_seq, in_acc && byte_ch.end_of_string |=> st_q == '0 && cnt_q != 2'd0)
	`U8PD_NEVER(a_no_take_while_group, cnt_q > 2'd1 && byte_ch.ready)

endmodule

// File: tb/sv/utf8pd_cp_checker.sv
// Checker of the permissive UTF-8 decoder: predicts the code points and compares them.
`timescale 1ns / 1ps
module utf8pd_cp_checker
	import utf8pd_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	utf8pd_in_if  byte_mon,
	utf8pd_out_if cp_mon,
	output int    fail_count,
	output int    pending
);

	typedef struct packed {
		logic [20:0] cp;
		logic        last;
	} cp_item_t;

	cp_item_t   expected_cps[$];
	logic [7:0] held[3];
	logic [1:0] held_cnt;
	logic [2:0] open_len;
	int         errors;

	function automatic logic [2:0] seq_len_of(input logic [7:0] b);
		casez (b)
			8'b0???????: return LEN_ASCII;
			8'b110?????: return LEN_TWO;
			8'b1110????: return LEN_THREE;
			8'b11110???: return LEN_FOUR;
			default:     return LEN_BAD;
		endcase
	endfunction

	function automatic logic [20:0] join_bytes(input logic [7:0] seq[4], input int start,
			input logic [2:0] len);
		logic [20:0] v;
		case (len)
			LEN_TWO:   v = {16'd0, seq[start][4:0]};
			LEN_THREE: v = {17'd0, seq[start][3:0]};
			default:   v = {18'd0, seq[start][2:0]};
		endcase
		for (int i = 1; i < int'(len); i++) begin
			v = {v[14:0], seq[start + i][5:0]};
		end
		return v;
	endfunction

	function automatic void push_cp(input logic [20:0] cp);
		cp_item_t item;
		item.cp = cp;
		item.last = 1'b0;
		expected_cps.insert(expected_cps.size(), item);
	endfunction

	// Works out the code points caused by one accepted byte and updates the open sequence.
	function automatic void predict_byte(input logic [7:0] b, input logic eos);
		logic [7:0] seq[4];
		logic [2:0] len;
		cp_item_t   tail;
		int         n;
		int         pos;
		int         k;
		seq = '{default: 8'h00};
		if (open_len == 3'd0) begin
			len = seq_len_of(b);
			if (len == LEN_ASCII) begin
				push_cp({13'd0, b});
			end else if (len == LEN_BAD || eos) begin
				push_cp(QMARK);
			end else begin
				held[0] = b;
				held_cnt = 2'd1;
				open_len = len;
			end
		end else begin
			for (int i = 0; i < int'(held_cnt); i++) begin
				seq[i] = held[i];
			end
			seq[held_cnt] = b;
			n = int'(held_cnt) + 1;
			if (n >= int'(open_len)) begin
				push_cp(join_bytes(seq, 0, open_len));
				held_cnt = 2'd0;
				open_len = 3'd0;
			end else if (eos) begin
				// The truncated lead gives '?', and what follows it is decoded afresh
				// as a string of its own.
				pos = 0;
				k = 0;
				while (pos < n && k < 3) begin
					len = seq_len_of(seq[pos]);
					if (len == LEN_ASCII) begin
						push_cp({13'd0, seq[pos]});
						pos++;
					end else if (len != LEN_BAD && pos + int'(len) <= n) begin
						push_cp(join_bytes(seq, pos, len));
						pos += int'(len);
					end else begin
						push_cp(QMARK);
						pos++;
					end
					k++;
				end
				held_cnt = 2'd0;
				open_len = 3'd0;
			end else begin
				held[held_cnt] = b;
				held_cnt = n[1:0];
			end
		end
		if (eos) begin
			tail = expected_cps.pop_back();
			tail.last = 1'b1;
			expected_cps.insert(expected_cps.size(), tail);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cp_item_t want;
		if (!arst_n) begin
			expected_cps.delete();
			held_cnt = 2'd0;
			open_len = 3'd0;
			errors = 0;
		end else begin
			if (byte_mon.valid && byte_mon.ready) begin
				predict_byte(byte_mon.byte_in, byte_mon.end_of_string);
			end
			if (cp_mon.valid && cp_mon.ready) begin
				if (expected_cps.size() == 0) begin
					$error("code point %h arrived with nothing expected", cp_mon.code_point);
					errors++;
				end else begin
					want = expected_cps.pop_front();
					if (cp_mon.code_point !== want.cp) begin
						$error("code_point: expected %h, got %h", want.cp, cp_mon.code_point);
						errors++;
					end
					if (cp_mon.last_of_string !== want.last) begin
						$error("last_of_string: expected %b, got %b", want.last,
							cp_mon.last_of_string);
						errors++;
					end
				end
			end
		end
		fail_count <= errors;
		pending <= expected_cps.size();
	end

endmodule

// File: tb/sv/utf8_permissive_decoder_tb.sv
// Testbench top of the permissive UTF-8 decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module utf8_permissive_decoder_tb;

	localparam int RANDOM_ITEMS = 75;
	localparam int HOLD_AT      = 40;
	localparam int LONG_HOLD    = 64;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic [7:0] b;
		logic       eos;
	} byte_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   accepted = 0;
	int   cycles = 0;

	byte_item_t stim_q[$];

	utf8pd_in_if  byte_ch ();
	utf8pd_out_if cp_ch ();

	utf8_permissive_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_ch(byte_ch),
		.cp_ch  (cp_ch)
	);

	utf8pd_cp_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_mon  (byte_ch),
		.cp_mon    (cp_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_byte(input logic [7:0] b, input logic eos);
		byte_item_t item;
		item.b = b;
		item.eos = eos;
		stim_q.insert(stim_q.size(), item);
	endtask

	function automatic logic [7:0] follow_byte();
		// Continuation bytes are not checked, so now and then any value is sent.
		if ($urandom_range(0, 3) == 0) begin
			return 8'($urandom);
		end
		return {2'b10, 6'($urandom)};
	endfunction

	function automatic logic [7:0] lead_byte(input int len);
		case (len)
			2:       return {3'b110, 5'($urandom)};
			3:       return {4'b1110, 4'($urandom)};
			default: return {5'b11110, 3'($urandom)};
		endcase
	endfunction

	// One string of mostly well-formed units with random content, sometimes cut short at its
	// end or salted with stray bytes; the final byte carries the end flag.
	task automatic add_random_string();
		int         units;
		int         len;
		byte_item_t tail;
		units = $urandom_range(1, 6);
		for (int u = 0; u < units; u++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: add_byte({1'b0, 7'($urandom)}, 1'b0);
				3, 4, 5, 6: begin
					len = $urandom_range(2, 4);
					add_byte(lead_byte(len), 1'b0);
					for (int i = 1; i < len; i++) begin
						add_byte(follow_byte(), 1'b0);
					end
				end
				7: add_byte({2'b10, 6'($urandom)}, 1'b0);
				8: add_byte({5'b11111, 3'($urandom)}, 1'b0);
				default: add_byte(8'($urandom), 1'b0);
			endcase
		end
		if ($urandom_range(0, 2) == 0) begin
			len = $urandom_range(2, 4);
			add_byte(lead_byte(len), 1'b0);
			for (int i = 0; i < $urandom_range(0, len - 2); i++) begin
				add_byte(($urandom_range(0, 2) == 0) ? 8'($urandom) : follow_byte(), 1'b0);
			end
		end
		tail = stim_q.pop_back();
		tail.eos = 1'b1;
		stim_q.insert(stim_q.size(), tail);
	endtask

	task automatic build_stimulus();
		int start;
		// Extremes of ASCII, then stray and invalid bytes with no sequence open.
		add_byte(8'h00, 1'b0);
		add_byte(8'h7F, 1'b1);
		add_byte(8'h80, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hF8, 1'b0);
		// Complete two, three and four byte sequences, the last one the highest value.
		add_byte(8'hC2, 1'b0);
		add_byte(8'hA9, 1'b0);
		add_byte(8'hE2, 1'b0);
		add_byte(8'h82, 1'b0);
		add_byte(8'hAC, 1'b1);
		add_byte(8'hF7, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b0);
		// A lead byte that is also the last byte of its string.
		add_byte(8'hC3, 1'b1);
		// String ends inside a sequence: the held lead gives '?' and the next byte is decoded afresh.
		add_byte(8'hE2, 1'b0);
		add_byte(8'h41, 1'b1);
		// Three leads in a row, each one short: three question marks at once.
		add_byte(8'hF0, 1'b0);
		add_byte(8'hE2, 1'b0);
		add_byte(8'hC3, 1'b1);
		// A following byte whose top bits are not those of a continuation.
		add_byte(8'hC0, 1'b0);
		add_byte(8'h3F, 1'b0);
		add_byte(8'hF0, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hC2, 1'b1);
		start = stim_q.size();
		while (stim_q.size() - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				for (int i = 0; i < $urandom_range(1, 6); i++) begin
					add_byte(8'($urandom), 1'($urandom));
				end
			end else begin
				add_random_string();
			end
		end
		// Close whatever the noise may have left open.
		add_byte(8'h2E, 1'b1);
	endtask

	task automatic send_all();
		int burst;
		burst = $urandom_range(1, 16);
		foreach (stim_q[i]) begin
			byte_ch.valid <= 1'b1;
			byte_ch.byte_in <= stim_q[i].b;
			byte_ch.end_of_string <= stim_q[i].eos;
			do @(posedge clk); while (!byte_ch.ready);
			accepted++;
			burst--;
			if (burst == 0) begin
				if ($urandom_range(0, 3) != 0) begin
					byte_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 5)) @(posedge clk);
				end
				burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 16);
			end
		end
		byte_ch.valid <= 1'b0;
	endtask

	initial begin
		byte_ch.valid <= 1'b0;
		byte_ch.byte_in <= 8'h00;
		byte_ch.end_of_string <= 1'b0;
		build_stimulus();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_all();
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// The receiver stalls by one of four random modes that it switches between, and once holds
	// off for a long stretch while bytes keep coming, so that the decoder backs up.
	initial begin
		int         cyc;
		int         mode;
		logic [15:0] pat;
		logic       hold_done;
		cyc = 0;
		mode = 0;
		pat = 16'hFFFF;
		hold_done = 1'b0;
		cp_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && accepted >= HOLD_AT) begin
				cp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end
			if (cyc % 24 == 0) begin
				mode = $urandom_range(0, 3);
				pat = 16'($urandom);
			end
			case (mode)
				0:       cp_ch.ready <= 1'b1;
				1:       cp_ch.ready <= 1'($urandom_range(0, 1));
				2:       cp_ch.ready <= ($urandom_range(0, 3) != 0);
				default: cp_ch.ready <= pat[cyc % 16];
			endcase
			cyc++;
		end
	end

endmodule

// File: sim.f
+incdir+design
design/utf8pd_pkg.sv
design/utf8pd_in_if.sv
design/utf8pd_out_if.sv
design/utf8pd_decode.sv
design/utf8_permissive_decoder.sv
tb/sv/utf8pd_cp_checker.sv
tb/sv/utf8_permissive_decoder_tb.sv
